// ===== rtl/core/cau_pkg.sv =====
package cau_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MAG = 3'd4,
        OP_EQU = 3'd5,
        OP_INC = 3'd6,
        OP_DEC = 3'd7
    } t_op;

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_RUN, S_FIN} t_st;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } t_item;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        eq;
        logic        dz;
        logic        ov;
    } t_res;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

endpackage

// ===== rtl/core/cau_front.sv =====
module cau_front
    import cau_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_busy,
    input  logic               i_pop,
    output logic               o_valid,
    output t_item              o_item
);

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    logic             push;

    assign o_busy  = (r_cnt == (QAW+1)'(QDEPTH));
    assign push    = i_start && !o_busy;
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{t_op'(i_operation), i_a_re, i_a_im, i_b_re, i_b_im};
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(push) - (QAW+1)'(i_pop);
        end
    end

endmodule

// ===== rtl/core/cau_back.sv =====
module cau_back
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_pop,
    output logic  o_done,
    output t_res  o_res
);

    // Divide runs 64 integer steps then FRAC_BITS fraction steps in one
    // register, so the quotient comes out as floor(n*2^F/m).
    localparam int DIVSTEPS  = 64 + FRAC_BITS;
    localparam int SQRTSTEPS = 32;

    // Three-stage pipe for everything but divide and magnitude; those run
    // iteratively in a shared bit-serial engine and hold the queue meanwhile.
    logic        r_v1;
    t_item       r_it;
    logic signed [63:0] r_p0, r_p1, r_p2, r_p3;
    logic        r_v2;
    t_op         r_op2;
    logic [31:0] r_aim2;
    logic        r_eq2;
    logic signed [33:0] r_sre, r_sim;

    t_st         r_st, n_st;
    logic        r_isdiv;
    logic        r_nre, r_nim;
    logic [63:0] r_m;
    logic [127:0] r_rre, r_rim;
    logic [63:0] r_qre, r_qim;
    logic        r_hre, r_him;
    logic [6:0]  r_cnt;
    logic        r_dz;

    logic serial;
    assign serial = i_valid && (i_item.op == OP_DIV || i_item.op == OP_MAG);
    assign o_pop  = i_valid && (serial ? (r_st == S_FIN) : (r_st == S_IDLE));

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (serial) n_st = S_LOAD;
            S_LOAD: n_st = S_MUL;
            S_MUL:  n_st = S_RUN;
            S_RUN:  if (r_cnt == (r_isdiv ? 7'(DIVSTEPS - 1) : 7'(SQRTSTEPS - 1)) || r_dz)
                        n_st = S_FIN;
            S_FIN:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    function automatic logic [31:0] sat(input logic neg, input logic [63:0] mag,
                                        output logic ov);
        ov = 1'b0;
        if (neg) begin
            if (mag > 64'h8000_0000) begin ov = 1'b1; return 32'h8000_0000; end
            return 32'(64'd0 - mag);
        end
        if (mag > 64'h7FFF_FFFF) begin ov = 1'b1; return 32'h7FFF_FFFF; end
        return mag[31:0];
    endfunction

    function automatic logic [64:0] sm(input logic signed [64:0] v);
        return v[64] ? {1'b1, 64'(-v)} : {1'b0, v[63:0]};
    endfunction

    logic [64:0] smre, smim;
    logic [63:0] sq;
    logic [127:0] n_rre, n_rim;
    logic signed [64:0] xre, xim;
    logic signed [63:0] bsq_re, bsq_im;

    assign bsq_re = r_it.b_re * r_it.b_re;
    assign bsq_im = r_it.b_im * r_it.b_im;

    always_comb begin
        xre = (r_op2 == OP_MUL) ? 65'(r_p0) - 65'(r_p1) : 65'(r_p0) + 65'(r_p1);
        xim = (r_op2 == OP_MUL) ? 65'(r_p2) + 65'(r_p3) : 65'(r_p3) - 65'(r_p2);
        smre = sm(xre);
        smim = sm(xim);
        sq   = 64'(r_p0) + 64'(r_p1);
        n_rre = {r_rre[126:0], 1'b0};
        n_rim = {r_rim[126:0], 1'b0};
    end

    // Stage 1: operand register; stage 2: products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_st <= S_IDLE;
        end else begin
            r_v1 <= o_pop && !serial;
            r_v2 <= r_v1;
            r_st <= n_st;
        end
        if (o_pop || (r_st == S_IDLE && serial)) r_it <= i_item;
        // products of the captured item
        r_p0 <= (r_it.op == OP_MAG) ? r_it.a_re * r_it.a_re : r_it.a_re * r_it.b_re;
        r_p1 <= (r_it.op == OP_MAG) ? r_it.a_im * r_it.a_im : r_it.a_im * r_it.b_im;
        r_p2 <= r_it.a_re * r_it.b_im;
        r_p3 <= r_it.a_im * r_it.b_re;
        r_op2 <= r_it.op;
        r_aim2 <= r_it.a_im;
        r_eq2 <= (r_it.a_re == r_it.b_re) && (r_it.a_im == r_it.b_im);
        r_sre <= (r_it.op == OP_ADD) ? 34'(r_it.a_re) + 34'(r_it.b_re) :
                 (r_it.op == OP_SUB) ? 34'(r_it.a_re) - 34'(r_it.b_re) :
                 (r_it.op == OP_INC) ? 34'(r_it.a_re) + (34'sd1 <<< FRAC_BITS) :
                                       34'(r_it.a_re) - (34'sd1 <<< FRAC_BITS);
        r_sim <= (r_it.op == OP_ADD) ? 34'(r_it.a_im) + 34'(r_it.b_im) :
                                       34'(r_it.a_im) - 34'(r_it.b_im);
    end

    // Serial engine: restoring divide of both parts, or bit-pair square root.
    logic [63:0] dre, dim;
    always_comb begin
        dre = r_rre[127:64];
        dim = r_rim[127:64];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: ;
            S_LOAD: ;
            S_MUL: begin
                r_isdiv <= (r_it.op == OP_DIV);
                r_cnt   <= '0;
                r_qre   <= '0;
                r_qim   <= '0;
                r_hre   <= 1'b0;
                r_him   <= 1'b0;
                if (r_it.op == OP_DIV) begin
                    r_m   <= bsq_re + bsq_im;
                    r_dz  <= (r_it.b_re == 0) && (r_it.b_im == 0);
                    r_nre <= smre[64];
                    r_nim <= smim[64];
                    r_rre <= {64'd0, smre[63:0]};
                    r_rim <= {64'd0, smim[63:0]};
                end else begin
                    r_m   <= '0;
                    r_dz  <= 1'b0;
                    r_rre <= {64'd0, sq};
                    r_rim <= '0;
                end
            end
            S_RUN: begin
                r_cnt <= r_cnt + 1'b1;
                if (r_isdiv) begin
                    // A quotient bit pushed past bit 63 means the result saturates.
                    r_hre <= r_hre | r_qre[63];
                    r_him <= r_him | r_qim[63];
                    if ({dre[62:0], r_rre[63]} >= r_m) begin
                        r_rre <= {{dre[62:0], r_rre[63]} - r_m, r_rre[62:0], 1'b0};
                        r_qre <= {r_qre[62:0], 1'b1};
                    end else begin
                        r_rre <= n_rre;
                        r_qre <= {r_qre[62:0], 1'b0};
                    end
                    if ({dim[62:0], r_rim[63]} >= r_m) begin
                        r_rim <= {{dim[62:0], r_rim[63]} - r_m, r_rim[62:0], 1'b0};
                        r_qim <= {r_qim[62:0], 1'b1};
                    end else begin
                        r_rim <= n_rim;
                        r_qim <= {r_qim[62:0], 1'b0};
                    end
                end else if (r_cnt < 7'd32) begin
                    // two radicand bits into the remainder each step
                    if ({r_rim[61:0], r_rre[63:62]} >= {r_qre[61:0], 2'b01}) begin
                        r_rim <= {r_rim[61:0], r_rre[63:62]} - {r_qre[61:0], 2'b01};
                        r_qre <= {r_qre[62:0], 1'b1};
                    end else begin
                        r_rim <= {r_rim[61:0], r_rre[63:62]};
                        r_qre <= {r_qre[62:0], 1'b0};
                    end
                    r_rre <= {r_rre[125:0], 2'b00};
                end
            end
            S_FIN: ;
            default: ;
        endcase
    end

    logic        ov_a, ov_b;
    logic [31:0] ore, oim;
    t_res        r_out;
    logic        r_done;
    logic [63:0] qre_s, qim_s;

    always_comb begin
        qre_s = r_hre ? '1 : r_qre;
        qim_s = r_him ? '1 : r_qim;
        ore = '0; oim = '0; ov_a = 1'b0; ov_b = 1'b0;
        if (r_isdiv) begin
            if (!r_dz) begin
                ore = sat(r_nre, qre_s, ov_a);
                oim = sat(r_nim, qim_s, ov_b);
            end
        end else begin
            ore = sat(1'b0, r_qre, ov_a);
        end
    end

    logic [31:0] pre, pim;
    logic        pova, povb;
    logic [63:0] fre, fim;
    always_comb begin
        fre = smre[64] ? (smre[63:0] + ((64'd1 << FRAC_BITS) - 64'd1)) >> FRAC_BITS
                       : smre[63:0] >> FRAC_BITS;
        fim = smim[64] ? (smim[63:0] + ((64'd1 << FRAC_BITS) - 64'd1)) >> FRAC_BITS
                       : smim[63:0] >> FRAC_BITS;
        pre = '0; pim = '0; pova = 1'b0; povb = 1'b0;
        case (r_op2)
            OP_MUL: begin
                pre = sat(smre[64], fre, pova);
                pim = sat(smim[64], fim, povb);
            end
            OP_ADD, OP_SUB: begin
                pre = sat(r_sre[33], r_sre[33] ? 64'(-r_sre) : 64'(r_sre), pova);
                pim = sat(r_sim[33], r_sim[33] ? 64'(-r_sim) : 64'(r_sim), povb);
            end
            OP_INC, OP_DEC: begin
                pre = sat(r_sre[33], r_sre[33] ? 64'(-r_sre) : 64'(r_sre), pova);
                pim = r_aim2;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= r_v2 || (r_st == S_FIN);
        if (r_st == S_FIN)
            r_out <= '{ore, oim, 1'b0, r_isdiv && r_dz, ov_a || ov_b};
        else
            r_out <= '{pre, pim, (r_op2 == OP_EQU) && r_eq2, 1'b0, pova || povb};
    end

    assign o_done = r_done;
    assign o_res  = r_out;

endmodule

// ===== rtl/core/complex_arithmetic_unit.sv =====
// Add, sub, mul, equal, inc and dec pass the operand, product and output registers to o_done.
// Divide and magnitude run in the serial engine; a zero divisor ends a divide early.
// Throughput: one transaction per cycle for pipelined operations while the back end
// is free; a divide or magnitude holds it until done, and later ones wait in the queue.
// Reset is synchronous, active low, and empties queue and pipeline.
// The receiver cannot stall: each result is shown for one cycle on o_done.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_operation,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_done,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output logic               o_is_equal,
    output logic               o_div_by_zero,
    output logic               o_overflow
);

    logic  pop, qv;
    t_item item;
    t_res  res;

    cau_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_operation, .i_a_re, .i_a_im,
        .i_b_re, .i_b_im, .o_busy(busy), .i_pop(pop), .o_valid(qv), .o_item(item)
    );

    cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(qv), .i_item(item), .o_pop(pop),
        .o_done, .o_res(res)
    );

    assign o_res_re      = res.re;
    assign o_res_im      = res.im;
    assign o_is_equal    = res.eq;
    assign o_div_by_zero = res.dz;
    assign o_overflow    = res.ov;

endmodule

// ===== rtl/core/cau_checker.sv =====
module cau_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_done,
    input logic        o_is_equal,
    input logic        o_div_by_zero,
    input logic        o_overflow,
    input logic [31:0] o_res_re,
    input logic [31:0] o_res_im
);

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_div_by_zero |-> o_res_re == 0 && o_res_im == 0 && !o_overflow)
        else $error("divide by zero result not zero");
    a_eq_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_is_equal |-> o_res_re == 0 && !o_div_by_zero)
        else $error("equal result carries data");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result after reset");

endmodule

bind complex_arithmetic_unit cau_checker u_chk (.*);
